// ===== design/mpqt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqt_pkg
// Shared types, operation codes and datapath step codes for the max-priority
// queue core.
// ----------------------------------------------------------------------------
package mpqt_pkg;

   localparam int FIELD_W = 16;

   // operation codes carried in the kind field
   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_PEEK = 2'd1;
   localparam logic [1:0] KIND_POP  = 2'd2;

   // datapath step codes issued by the controller
   localparam logic [2:0] STEP_NONE = 3'd0;
   localparam logic [2:0] STEP_PUSH = 3'd1;
   localparam logic [2:0] STEP_UP   = 3'd2;
   localparam logic [2:0] STEP_POP  = 3'd3;
   localparam logic [2:0] STEP_LOAD = 3'd4;
   localparam logic [2:0] STEP_DOWN = 3'd5;
   localparam logic [2:0] STEP_RESP = 3'd6;

   typedef struct packed {
      logic [FIELD_W-1:0] score;
      logic [FIELD_W-1:0] id;
      logic [FIELD_W-1:0] tag;
   } mpqt_rec_type;

   typedef struct packed {
      logic [2:0] step;
      logic       dropped;
   } mpqt_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_one;
      logic full;
      logic up_done;
      logic down_done;
      logic rsp_free;
   } mpqt_status_type;

   // higher score first, smaller id on a tie
   function automatic logic outranks(input mpqt_rec_type a, input mpqt_rec_type b);
      logic [2*FIELD_W-1:0] key_a;
      logic [2*FIELD_W-1:0] key_b;
      key_a = {a.score, ~a.id};
      key_b = {b.score, ~b.id};
      return key_a > key_b;
   endfunction

endpackage

// ===== design/mpqt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqt_if
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface mpqt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] entry_score;
   logic [15:0] entry_id;
   logic [15:0] entry_tag;

   modport source (output valid, kind, entry_score, entry_id, entry_tag, input ready);
   modport sink   (input valid, kind, entry_score, entry_id, entry_tag, output ready);
endinterface

interface mpqt_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_empty;
   logic [15:0] top_score;
   logic [15:0] top_id;
   logic [15:0] top_tag;
   logic        push_dropped;

   modport source (output valid, is_empty, top_score, top_id, top_tag, push_dropped,
                   input ready);
   modport sink   (input valid, is_empty, top_score, top_id, top_tag, push_dropped,
                   output ready);
endinterface

// ===== design/mpqt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqt_ctrl
// Sequencer: accepts one request word, steps the heap datapath through
// sift-up or sift-down one level a cycle, then loads the response.
// ----------------------------------------------------------------------------
module mpqt_ctrl
   import mpqt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [1:0]      req_kind,
   output logic            req_ready,
   input  mpqt_status_type status,
   output mpqt_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_UP   = 3'd1;
   localparam logic [2:0] ST_LOAD = 3'd2;
   localparam logic [2:0] ST_DOWN = 3'd3;
   localparam logic [2:0] ST_RESP = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       dropped_ff, dropped_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      dropped_in  = dropped_ff;
      cmd.step    = STEP_NONE;
      cmd.dropped = dropped_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dropped_in = 1'b0;
               state_in   = ST_RESP;
               if (req_kind == KIND_PUSH) begin
                  if (status.full) begin
                     dropped_in = 1'b1;
                  end else begin
                     cmd.step = STEP_PUSH;
                     state_in = ST_UP;
                  end
               end else if (req_kind == KIND_POP && !status.count_zero) begin
                  cmd.step = STEP_POP;
                  // last record leaving: nothing to sift
                  if (!status.count_one) begin
                     state_in = ST_LOAD;
                  end
               end
            end
         end
         ST_UP: begin
            cmd.step = STEP_UP;
            if (status.up_done) begin
               state_in = ST_RESP;
            end
         end
         ST_LOAD: begin
            cmd.step = STEP_LOAD;
            state_in = ST_DOWN;
         end
         ST_DOWN: begin
            cmd.step = STEP_DOWN;
            if (status.down_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.step = STEP_RESP;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule

// ===== design/mpqt_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqt_dpath
// Heap datapath: record store with one write and two registered read ports,
// entry count, moving record and hole position, root copy and response word.
// ----------------------------------------------------------------------------
module mpqt_dpath
   import mpqt_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  logic            clock,
   input  logic            reset,
   input  mpqt_cmd_type    cmd,
   output mpqt_status_type status,
   input  mpqt_rec_type    req_rec,
   input  logic            rsp_ready,
   output logic            rsp_valid,
   output logic            rsp_is_empty,
   output mpqt_rec_type    rsp_rec,
   output logic            rsp_dropped
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int LW = AW + 2;

   mpqt_rec_type heap_mem [CAPACITY];

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   mpqt_rec_type  cur_ff, cur_in;
   mpqt_rec_type  top_ff;
   mpqt_rec_type  rd_a_ff, rd_b_ff;

   logic          rsp_valid_ff;
   logic          rsp_empty_ff;
   mpqt_rec_type  rsp_rec_ff;
   logic          rsp_dropped_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   mpqt_rec_type  wr_data;
   logic [AW-1:0] rd_a_addr, rd_b_addr;

   // sift-up helpers
   logic [AW-1:0] cnt_a, cnt_a_par, pos_par, pos_parpar;
   logic          cur_wins_par;

   // sift-down helpers
   logic [LW-1:0] left_w, right_w, cnt_w, best_w;
   logic          left_ok, right_ok, take_right, do_swap;
   mpqt_rec_type  best_rec;
   logic [AW-1:0] down_src;
   logic [AW:0]   child_l;
   logic [LW-1:0] child_r;

   assign cnt_a      = count_ff[AW-1:0];
   assign cnt_a_par  = (cnt_a - {{(AW-1){1'b0}}, 1'b1}) >> 1;
   assign pos_par    = (pos_ff - {{(AW-1){1'b0}}, 1'b1}) >> 1;
   assign pos_parpar = (pos_par - {{(AW-1){1'b0}}, 1'b1}) >> 1;
   assign cur_wins_par = outranks(cur_ff, rd_a_ff);

   assign left_w     = LW'({pos_ff, 1'b1});
   assign right_w    = left_w + LW'(1);
   assign cnt_w      = LW'(count_ff);
   assign left_ok    = left_w < cnt_w;
   assign right_ok   = right_w < cnt_w;
   assign take_right = right_ok && outranks(rd_b_ff, rd_a_ff);
   assign best_rec   = take_right ? rd_b_ff : rd_a_ff;
   assign best_w     = take_right ? right_w : left_w;
   assign do_swap    = left_ok && outranks(best_rec, cur_ff);

   // children of the next hole
   assign down_src = (cmd.step == STEP_LOAD) ? '0 : best_w[AW-1:0];
   assign child_l  = {down_src, 1'b1};
   assign child_r  = LW'(child_l) + LW'(1);

   assign status.count_zero = (count_ff == '0);
   assign status.count_one  = (count_ff == CW'(1));
   assign status.full       = (count_ff == CW'(CAPACITY));
   assign status.up_done    = (pos_ff == '0) || !cur_wins_par;
   assign status.down_done  = !do_swap;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = cur_ff;
      rd_a_addr = pos_parpar;
      rd_b_addr = child_r[AW-1:0];
      case (cmd.step)
         STEP_PUSH: begin
            cur_in    = req_rec;
            pos_in    = cnt_a;
            count_in  = count_ff + CW'(1);
            rd_a_addr = cnt_a_par;
         end
         STEP_UP: begin
            rd_a_addr = pos_parpar;
            wr_en     = 1'b1;
            if (pos_ff != '0 && cur_wins_par) begin
               // parent drops into the hole, hole moves up
               wr_data = rd_a_ff;
               pos_in  = pos_par;
            end
         end
         STEP_POP: begin
            count_in  = count_ff - CW'(1);
            rd_a_addr = AW'(count_ff - CW'(1));
         end
         STEP_LOAD: begin
            cur_in    = rd_a_ff;
            pos_in    = '0;
            rd_a_addr = child_l[AW-1:0];
            rd_b_addr = child_r[AW-1:0];
         end
         STEP_DOWN: begin
            rd_a_addr = child_l[AW-1:0];
            rd_b_addr = child_r[AW-1:0];
            wr_en     = 1'b1;
            if (do_swap) begin
               wr_data = best_rec;
               pos_in  = best_w[AW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_a_addr];
      rd_b_ff <= heap_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      cur_ff <= cur_in;
      if (wr_en && wr_addr == '0) begin
         top_ff <= wr_data;
      end
      if (cmd.step == STEP_RESP) begin
         rsp_empty_ff   <= (count_ff == '0);
         rsp_rec_ff     <= (count_ff == '0) ? '0 : top_ff;
         rsp_dropped_ff <= cmd.dropped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.step == STEP_RESP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_empty = rsp_empty_ff;
   assign rsp_rec      = rsp_rec_ff;
   assign rsp_dropped  = rsp_dropped_ff;

endmodule

// ===== design/max_priority_queue_tiebreak_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_tiebreak_core
// Bounded max-priority queue of {score, id, tag} records held as a binary
// heap in a two-read, one-write record store.
// ----------------------------------------------------------------------------
// Each request word (push, peek or pop) returns one response word carrying
// the record now at the top or an empty flag; higher score wins, smaller id
// wins a tie. One request is in progress at a time. A peek, a dropped push
// and a pop that empties the queue go from acceptance straight to the
// response step; a push first sifts the new record up, and a pop first
// moves the last record to the root and sifts it down, at most log2(CAPACITY)
// levels. The heap walk advances one level per cycle, set by the registered
// read of the record store. The response sits in an output register, so the
// next request is accepted while a response still waits to be taken.
// ----------------------------------------------------------------------------
module max_priority_queue_tiebreak_core
   import mpqt_pkg::*;
#(
   parameter int CAPACITY = 1024
)
(
   input  logic     clock,
   input  logic     reset,
   mpqt_req_if.sink   req_ch,
   mpqt_rsp_if.source rsp_ch
);

   mpqt_cmd_type    cmd;
   mpqt_status_type status;
   mpqt_rec_type    req_rec;
   mpqt_rec_type    rsp_rec;
   logic            req_ready;

   assign req_rec.score = req_ch.entry_score;
   assign req_rec.id    = req_ch.entry_id;
   assign req_rec.tag   = req_ch.entry_tag;
   assign req_ch.ready  = req_ready;

   mpqt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mpqt_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_rec      (req_rec),
      .rsp_ready    (rsp_ch.ready),
      .rsp_valid    (rsp_ch.valid),
      .rsp_is_empty (rsp_ch.is_empty),
      .rsp_rec      (rsp_rec),
      .rsp_dropped  (rsp_ch.push_dropped)
   );

   assign rsp_ch.top_score = rsp_rec.score;
   assign rsp_ch.top_id    = rsp_rec.id;
   assign rsp_ch.top_tag   = rsp_rec.tag;

endmodule
